@@ rtl/pua_pkg.sv @@
`timescale 1ns / 1ps
// ============================================================================
// pua_pkg
// Shared constants for the polar unwrap address generator: default widths,
// register indexes and the fixed-point constants of the sine series.
// ============================================================================
package pua_pkg;

    // Default widths of the coordinate outputs and of the phase path.
    localparam int COORD_BITS_DEF = 12;
    localparam int PHASE_BITS_DEF = 16;

    // Configuration register indexes.
    localparam logic [2:0] CFG_SOURCE_DIAMETER = 3'd0;
    localparam logic [2:0] CFG_SOURCE_HEIGHT   = 3'd1;
    localparam logic [2:0] CFG_OUT_ROWS        = 3'd2;
    localparam logic [2:0] CFG_OUT_COLS        = 3'd3;
    localparam logic [2:0] CFG_START_PHASE     = 3'd4;

    // Pi in Q2.30 and one in Q30.
    localparam logic [31:0] PI_Q30  = 32'd3373259426;
    localparam logic [30:0] ONE_Q30 = 31'h4000_0000;

    // Taylor series denominators, innermost first, and floor(2^32 / d).
    localparam int SIN_TERMS = 5;
    localparam logic [31:0] TERM_DIV [SIN_TERMS] = '{
        32'd110, 32'd72, 32'd42, 32'd20, 32'd6
    };
    localparam logic [31:0] TERM_RECIP [SIN_TERMS] = '{
        32'd39045157, 32'd59652323, 32'd102261126, 32'd214748364, 32'd715827882
    };

    // Register stages through the sine unit.
    localparam int SIN_LAT = 5 + 3 * SIN_TERMS;

endpackage

@@ rtl/pua_sin.sv @@
`timescale 1ns / 1ps
// ============================================================================
// pua_sin
// Pipelined Q1.15 sine of a phase word: quadrant fold, angle in Q2.30, and a
// Taylor series to x^11 evaluated in nested form, one term every three stages.
// ============================================================================
module pua_sin
    import pua_pkg::*;
#(
    parameter int PHASE_BITS = PHASE_BITS_DEF
)
(
    input  logic                  clk,
    input  logic [PHASE_BITS-1:0] phase,
    output logic signed [15:0]    sin_val
);

    localparam int FW      = PHASE_BITS - 1;
    localparam int QUARTER = 1 << (PHASE_BITS - 2);
    localparam int XPIPE   = 3 * SIN_TERMS;

    // Stage 1: fold the quarter wave by quadrant.
    logic [FW-1:0] frac;
    logic [FW-1:0] f_next;
    logic [FW-1:0] f_reg;
    logic          neg_pipe [0:SIN_LAT-2];

    always_comb
    begin
        frac   = {1'b0, phase[PHASE_BITS-3:0]};
        f_next = phase[PHASE_BITS-2] ? (FW'(QUARTER) - frac) : frac;
    end

    // The half-turn sign travels alongside the data.
    always_ff @(posedge clk)
    begin
        f_reg       <= f_next;
        neg_pipe[0] <= phase[PHASE_BITS-1];
        for (int i = 1; i < SIN_LAT - 1; i++)
        begin
            neg_pipe[i] <= neg_pipe[i-1];
        end
    end

    // Stage 2: angle in Q2.30.
    logic [FW+31:0] fx_prod;
    logic [30:0]    x_reg;

    assign fx_prod = (FW+32)'(f_reg) * (FW+32)'(PI_Q30);

    always_ff @(posedge clk)
    begin
        x_reg <= fx_prod[FW+30:FW];
    end

    // Stage 3: square of the angle; the angle and its square are delayed
    // to meet each term of the series.
    logic [61:0] xx_prod;
    logic [31:0] x2_pipe [0:XPIPE];
    logic [30:0] x_pipe  [0:XPIPE];

    assign xx_prod = 62'(x_reg) * 62'(x_reg);

    always_ff @(posedge clk)
    begin
        x2_pipe[0] <= xx_prod[61:30];
        x_pipe[0]  <= x_reg;
        for (int i = 1; i <= XPIPE; i++)
        begin
            x2_pipe[i] <= x2_pipe[i-1];
            x_pipe[i]  <= x_pipe[i-1];
        end
    end

    // Nested series: t = 1 - (x2 * t) / d, three stages per term.
    logic [30:0] t_arr [0:SIN_TERMS];

    assign t_arr[0] = ONE_Q30;

    for (genvar i = 0; i < SIN_TERMS; i++)
    begin : g_term
        logic [63:0] pt_prod;
        logic [63:0] qm_prod;
        logic [31:0] rem;
        logic [31:0] q_fix;
        logic [31:0] p_reg;
        logic [31:0] pb_reg;
        logic [31:0] qe_reg;
        logic [30:0] t_reg;

        // Product of x squared and the running term.
        assign pt_prod = 64'(x2_pipe[3*i]) * 64'(t_arr[i]);

        always_ff @(posedge clk)
        begin
            p_reg <= pt_prod[61:30];
        end

        // Quotient estimate by reciprocal; it is low by at most one.
        assign qm_prod = 64'(p_reg) * 64'(TERM_RECIP[i]);

        always_ff @(posedge clk)
        begin
            qe_reg <= qm_prod[63:32];
            pb_reg <= p_reg;
        end

        // Correct the estimate and form the next term.
        always_comb
        begin
            rem   = pb_reg - 32'(qe_reg * TERM_DIV[i]);
            q_fix = (rem >= TERM_DIV[i]) ? (qe_reg + 32'd1) : qe_reg;
        end

        always_ff @(posedge clk)
        begin
            t_reg <= 31'(32'(ONE_Q30) - q_fix);
        end

        assign t_arr[i+1] = t_reg;
    end

    // Multiply by x to finish the series.
    logic [61:0] sx_prod;
    logic [30:0] s_reg;

    assign sx_prod = 62'(x_pipe[XPIPE]) * 62'(t_arr[SIN_TERMS]);

    always_ff @(posedge clk)
    begin
        s_reg <= sx_prod[60:30];
    end

    // Round half up to Q15, saturate and apply the sign.
    logic [31:0] s_round;
    logic [15:0] s_mag;

    always_comb
    begin
        s_round = (32'(s_reg) + 32'd16384) >> 15;
        s_mag   = (s_round > 32'd32767) ? 16'd32767 : s_round[15:0];
    end

    always_ff @(posedge clk)
    begin
        sin_val <= neg_pipe[SIN_LAT-2] ? -$signed(s_mag) : $signed(s_mag);
    end

endmodule

@@ rtl/polar_unwrap_address_generator.sv @@
`timescale 1ns / 1ps
// ============================================================================
// polar_unwrap_address_generator
// Maps an unwrapped panorama pixel to its source pixel in a circular fisheye
// image, with a flag that tells whether that source pixel exists.
// ============================================================================
// A new item is taken in every clock cycle: busy stays low, and each item's
// result appears with done high. Each item passes through the two long
// dividers for angle and radius, one quotient bit per stage, followed by the
// pipelined sine series. Results cannot be held off: the receiver must take
// done when it comes. Configuration writes are always ready and must only be
// made while no item is in flight.
module polar_unwrap_address_generator
    import pua_pkg::*;
#(
    parameter int COORD_BITS = COORD_BITS_DEF,
    parameter int PHASE_BITS = PHASE_BITS_DEF
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  start,
    output logic                  busy,
    input  logic [11:0]           out_col,
    input  logic [11:0]           out_row,
    output logic                  done,
    output logic [COORD_BITS-1:0] source_x,
    output logic [COORD_BITS-1:0] source_y,
    output logic                  in_range,
    input  logic                  cfg_valid,
    output logic                  cfg_ready,
    input  logic [2:0]            cfg_index,
    input  logic [15:0]           cfg_data
);

    localparam int W1      = 12 + PHASE_BITS;
    localparam int W2      = 31;
    localparam int DS      = (W1 > W2) ? W1 : W2;
    localparam int TOT     = DS + 26;
    localparam int QUARTER = 1 << (PHASE_BITS - 2);
    localparam int VW      = 42;
    localparam int TW      = 18;

    assign busy      = 1'b0;
    assign cfg_ready = 1'b1;

    // Configuration registers.
    logic [11:0] diam_reg;
    logic [11:0] height_reg;
    logic [11:0] rows_reg;
    logic [11:0] cols_reg;
    logic [15:0] phase0_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            diam_reg   <= 12'd512;
            height_reg <= 12'd512;
            rows_reg   <= 12'd256;
            cols_reg   <= 12'd1024;
            phase0_reg <= 16'd0;
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                CFG_SOURCE_DIAMETER: diam_reg   <= cfg_data[11:0];
                CFG_SOURCE_HEIGHT:   height_reg <= cfg_data[11:0];
                CFG_OUT_ROWS:        rows_reg   <= cfg_data[11:0];
                CFG_OUT_COLS:        cols_reg   <= cfg_data[11:0];
                CFG_START_PHASE:     phase0_reg <= cfg_data;
                default:             ;
            endcase
        end
    end

    // A zero row or column count divides as one.
    logic [11:0] cols_eff;
    logic [11:0] rows_eff;

    assign cols_eff = (cols_reg == 12'd0) ? 12'd1 : cols_reg;
    assign rows_eff = (rows_reg == 12'd0) ? 12'd1 : rows_reg;

    // Valid bits, one per stage.
    logic vld_reg [0:TOT-1];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < TOT; i++)
            begin
                vld_reg[i] <= 1'b0;
            end
        end
        else
        begin
            vld_reg[0] <= start && !busy;
            for (int i = 1; i < TOT; i++)
            begin
                vld_reg[i] <= vld_reg[i-1];
            end
        end
    end

    // Input stage: load both dividends; the radius dividend is row * diameter * 128.
    logic [11:0]   rem1_reg [0:DS];
    logic [W1-1:0] num1_reg [0:DS];
    logic [11:0]   rem2_reg [0:DS];
    logic [W2-1:0] num2_reg [0:DS];
    logic [23:0]   rd_prod;

    assign rd_prod = 24'(out_row) * 24'(diam_reg);

    always_ff @(posedge clk)
    begin
        rem1_reg[0] <= '0;
        num1_reg[0] <= {out_col, {PHASE_BITS{1'b0}}};
        rem2_reg[0] <= '0;
        num2_reg[0] <= {rd_prod, 7'd0};
    end

    // Long division: each divider makes one quotient bit per stage until done.
    for (genvar k = 0; k < DS; k++)
    begin : g_div
        logic [12:0]   t1;
        logic [12:0]   t2;
        logic          ge1;
        logic          ge2;
        logic [11:0]   rem1_next;
        logic [11:0]   rem2_next;
        logic [W1-1:0] num1_next;
        logic [W2-1:0] num2_next;

        always_comb
        begin
            t1  = {rem1_reg[k], num1_reg[k][W1-1]};
            t2  = {rem2_reg[k], num2_reg[k][W2-1]};
            ge1 = (t1 >= {1'b0, cols_eff});
            ge2 = (t2 >= {1'b0, rows_eff});
            if (k < W1)
            begin
                rem1_next = ge1 ? 12'(t1 - {1'b0, cols_eff}) : t1[11:0];
                num1_next = {num1_reg[k][W1-2:0], ge1};
            end
            else
            begin
                rem1_next = rem1_reg[k];
                num1_next = num1_reg[k];
            end
            if (k < W2)
            begin
                rem2_next = ge2 ? 12'(t2 - {1'b0, rows_eff}) : t2[11:0];
                num2_next = {num2_reg[k][W2-2:0], ge2};
            end
            else
            begin
                rem2_next = rem2_reg[k];
                num2_next = num2_reg[k];
            end
        end

        always_ff @(posedge clk)
        begin
            rem1_reg[k+1] <= rem1_next;
            num1_reg[k+1] <= num1_next;
            rem2_reg[k+1] <= rem2_next;
            num2_reg[k+1] <= num2_next;
        end
    end

    // Phase and radius: add the start angle, saturate the radius to Q12.8.
    logic [PHASE_BITS+15:0] phase0_wide;
    logic [PHASE_BITS-1:0]  phase_sum;
    logic [PHASE_BITS-1:0]  phase_s_reg;
    logic [PHASE_BITS-1:0]  phase_c_reg;
    logic [19:0]            r_sat;
    logic [19:0]            r_pipe [0:SIN_LAT];

    always_comb
    begin
        phase0_wide = {phase0_reg, {PHASE_BITS{1'b0}}};
        phase_sum   = phase0_wide[PHASE_BITS+15:16] + num1_reg[DS][PHASE_BITS-1:0];
        r_sat       = (num2_reg[DS] > W2'(20'hFFFFF)) ? 20'hFFFFF : num2_reg[DS][19:0];
    end

    always_ff @(posedge clk)
    begin
        phase_s_reg <= phase_sum;
        phase_c_reg <= phase_sum + PHASE_BITS'(QUARTER);
        r_pipe[0]   <= r_sat;
        for (int i = 1; i <= SIN_LAT; i++)
        begin
            r_pipe[i] <= r_pipe[i-1];
        end
    end

    // Sine and cosine units.
    logic signed [15:0] sin_val;
    logic signed [15:0] cos_val;

    pua_sin #(
        .PHASE_BITS (PHASE_BITS)
    ) u_sin (
        .clk     (clk),
        .phase   (phase_s_reg),
        .sin_val (sin_val)
    );

    pua_sin #(
        .PHASE_BITS (PHASE_BITS)
    ) u_cos (
        .clk     (clk),
        .phase   (phase_c_reg),
        .sin_val (cos_val)
    );

    // Radius times cosine and sine; the radius is delayed by the sine latency.
    logic signed [36:0] rc_reg;
    logic signed [36:0] rs_reg;

    always_ff @(posedge clk)
    begin
        rc_reg <= $signed({1'b0, r_pipe[SIN_LAT]}) * cos_val;
        rs_reg <= $signed({1'b0, r_pipe[SIN_LAT]}) * sin_val;
    end

    // Add the center in Q.23.
    logic signed [VW-1:0] cen_w;
    logic signed [VW-1:0] vx_reg;
    logic signed [VW-1:0] vy_reg;

    always_comb
    begin
        cen_w = ($signed({{(VW-12){1'b0}}, diam_reg}) - VW'(1)) <<< 22;
    end

    always_ff @(posedge clk)
    begin
        vx_reg <= cen_w + VW'(rc_reg);
        vy_reg <= cen_w - VW'(rs_reg);
    end

    // Truncate toward zero to whole pixels.
    logic [VW-1:0]        mag_x;
    logic [VW-1:0]        mag_y;
    logic signed [TW-1:0] tx_reg;
    logic signed [TW-1:0] ty_reg;

    always_comb
    begin
        mag_x = vx_reg[VW-1] ? VW'(-vx_reg) : VW'(vx_reg);
        mag_y = vy_reg[VW-1] ? VW'(-vy_reg) : VW'(vy_reg);
    end

    always_ff @(posedge clk)
    begin
        tx_reg <= vx_reg[VW-1] ? -$signed(mag_x[22+TW:23]) : $signed(mag_x[22+TW:23]);
        ty_reg <= vy_reg[VW-1] ? -$signed(mag_y[22+TW:23]) : $signed(mag_y[22+TW:23]);
    end

    // Bound check and clamp into the output range.
    logic signed [TW-1:0] clamp_top;
    logic                 ok;

    always_comb
    begin
        clamp_top = $signed(TW'((1 << COORD_BITS) - 1));
        ok = !tx_reg[TW-1] && (tx_reg < $signed({{(TW-12){1'b0}}, diam_reg})) &&
             !ty_reg[TW-1] && (ty_reg < $signed({{(TW-12){1'b0}}, height_reg}));
    end

    always_ff @(posedge clk)
    begin
        if (tx_reg[TW-1])
            source_x <= '0;
        else if (tx_reg > clamp_top)
            source_x <= clamp_top[COORD_BITS-1:0];
        else
            source_x <= tx_reg[COORD_BITS-1:0];
        if (ty_reg[TW-1])
            source_y <= '0;
        else if (ty_reg > clamp_top)
            source_y <= clamp_top[COORD_BITS-1:0];
        else
            source_y <= ty_reg[COORD_BITS-1:0];
        in_range <= ok;
    end

    assign done = vld_reg[TOT-1];

endmodule

@@ test/testbench.sv @@
`timescale 1ns / 1ps
// ============================================================================
// testbench
// Checks the polar unwrap address generator against a cycle-free predictor
// of its fixed-point mapping, over several register settings, with random
// gaps between items and a per-field comparison of every result.
// ============================================================================
module testbench;
    import pua_pkg::*;

    typedef struct packed {
        logic [11:0] col;
        logic [11:0] row;
    } pixel_t;

    typedef struct packed {
        logic [11:0] x;
        logic [11:0] y;
        logic        ok;
    } source_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        start = 1'b0;
    logic        busy;
    logic [11:0] out_col = '0;
    logic [11:0] out_row = '0;
    logic        done;
    logic [11:0] source_x;
    logic [11:0] source_y;
    logic        in_range;
    logic        cfg_valid = 1'b0;
    logic        cfg_ready;
    logic [2:0]  cfg_index = CFG_SOURCE_DIAMETER;
    logic [15:0] cfg_data = '0;

    // Register copies used by the predictor.
    logic [11:0] diameter_reg = 12'd512;
    logic [11:0] height_reg = 12'd512;
    logic [11:0] rows_reg = 12'd256;
    logic [11:0] cols_reg = 12'd1024;
    logic [15:0] phase_reg = 16'd0;

    pixel_t  pending_pixels[$];
    source_t expected_sources[$];
    int      mismatches = 0;
    int      gap_left = 0;
    bit      no_gaps = 0;

    polar_unwrap_address_generator dut (
        .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
        .out_col(out_col), .out_row(out_row), .done(done),
        .source_x(source_x), .source_y(source_y), .in_range(in_range),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
        .cfg_index(cfg_index), .cfg_data(cfg_data)
    );

    initial
    begin
        forever #5 clk = ~clk;
    end

    // Q1.15 sine of a 16-bit phase, quarter wave folded by quadrant.
    function automatic longint fisheye_sine(input logic [15:0] p);
        longint unsigned divs[5] = '{110, 72, 42, 20, 6};
        longint unsigned f, x, x2, t, s;
        logic [1:0] q;
        q = p[15:14];
        f = p[13:0];
        if (q[0])
            f = 16384 - f;
        x = (f * 64'd3373259426) >> 15;
        x2 = (x * x) >> 30;
        t = 64'd1 << 30;
        for (int i = 0; i < 5; i++)
            t = (64'd1 << 30) - ((x2 * t) >> 30) / divs[i];
        s = (x * t) >> 30;
        s = (s + 64'd16384) >> 15;
        if (s > 32767)
            s = 32767;
        return q[1] ? -longint'(s) : longint'(s);
    endfunction

    // Q.23 value truncated toward zero.
    function automatic longint trunc_q23(input longint v);
        return (v < 0) ? -((-v) >>> 23) : (v >>> 23);
    endfunction

    function automatic logic [11:0] clamp_coord(input longint v);
        if (v < 0)
            return 12'd0;
        if (v > 4095)
            return 12'd4095;
        return v[11:0];
    endfunction

    // Maps one output pixel to its expected source pixel.
    function automatic source_t map_pixel(input pixel_t px);
        longint unsigned rows, cols, r;
        logic [15:0] phase;
        longint s, c, center, x, y;
        source_t res;
        rows = (rows_reg == 0) ? 1 : rows_reg;
        cols = (cols_reg == 0) ? 1 : cols_reg;
        phase = 16'(phase_reg + ((64'(px.col) << 16) / cols));
        s = fisheye_sine(phase);
        c = fisheye_sine(phase + 16'd16384);
        r = (64'(px.row) * diameter_reg * 128) / rows;
        if (r > 64'hFFFFF)
            r = 64'hFFFFF;
        center = (longint'(diameter_reg) - 1) * 128;
        x = trunc_q23(center * 32768 + longint'(r) * c);
        y = trunc_q23(center * 32768 - longint'(r) * s);
        res.ok = x >= 0 && x < diameter_reg && y >= 0 && y < height_reg;
        res.x = clamp_coord(x);
        res.y = clamp_coord(y);
        return res;
    endfunction

    function automatic int pick_gap();
        int roll;
        roll = $urandom_range(99);
        if (no_gaps || roll < 65)
            return 0;
        if (roll < 95)
            return $urandom_range(3, 1);
        return $urandom_range(40, 10);
    endfunction

    // Driver: presents queued items and records the expectation at acceptance.
    always @(posedge clk or negedge rst_n)
    begin : driver
        pixel_t px;
        if (!rst_n)
        begin
            start <= 1'b0;
            gap_left = 0;
        end
        else
        begin
            if (start && !busy)
            begin
                expected_sources.push_back(map_pixel('{col: out_col, row: out_row}));
                gap_left = pick_gap();
            end
            if (start && busy)
                start <= 1'b1;
            else if (gap_left > 0)
            begin
                gap_left--;
                start <= 1'b0;
            end
            else if (pending_pixels.size() > 0)
            begin
                px = pending_pixels.pop_front();
                start <= 1'b1;
                out_col <= px.col;
                out_row <= px.row;
            end
            else
                start <= 1'b0;
        end
    end

    // Monitor: compares each strobed result with the oldest expectation.
    always @(posedge clk)
    begin : monitor
        source_t want;
        if (rst_n && done)
        begin
            if (expected_sources.size() == 0)
            begin
                $error("result with no item outstanding: x=%0d y=%0d in_range=%0b",
                       source_x, source_y, in_range);
                mismatches++;
            end
            else
            begin
                want = expected_sources.pop_front();
                if (source_x !== want.x)
                begin
                    $error("source_x: expected %0d, got %0d", want.x, source_x);
                    mismatches++;
                end
                if (source_y !== want.y)
                begin
                    $error("source_y: expected %0d, got %0d", want.y, source_y);
                    mismatches++;
                end
                if (in_range !== want.ok)
                begin
                    $error("in_range: expected %0b, got %0b", want.ok, in_range);
                    mismatches++;
                end
            end
        end
    end

    task automatic write_reg(input logic [2:0] idx, input logic [15:0] value);
        @(posedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= value;
        do
            @(posedge clk);
        while (!cfg_ready);
        cfg_valid <= 1'b0;
        case (idx)
            CFG_SOURCE_DIAMETER: diameter_reg = value[11:0];
            CFG_SOURCE_HEIGHT:   height_reg = value[11:0];
            CFG_OUT_ROWS:        rows_reg = value[11:0];
            CFG_OUT_COLS:        cols_reg = value[11:0];
            CFG_START_PHASE:     phase_reg = value;
            default: ;
        endcase
    endtask

    // Waits until every item has been taken and answered, then lets the
    // pipeline drain past its latency.
    task automatic wait_idle();
        while (pending_pixels.size() != 0 || start || expected_sources.size() != 0)
            @(posedge clk);
        repeat (70) @(posedge clk);
    endtask

    function automatic logic [11:0] pick_reg(input logic [11:0] typical);
        int roll;
        roll = $urandom_range(99);
        if (roll < 10)
            return 12'd1;
        if (roll < 20)
            return 12'd4095;
        if (roll < 24)
            return 12'd0;
        if (roll < 60)
            return typical;
        return 12'($urandom_range(4095, 1));
    endfunction

    initial
    begin : stimulus
        logic [11:0] dia, hgt, rws, cls;
        logic [15:0] sp;
        pixel_t px;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;

        // Directed items at the reset settings: field extremes and quadrants.
        no_gaps = 1;
        pending_pixels.push_back('{col: 12'd0, row: 12'd0});
        pending_pixels.push_back('{col: 12'd4095, row: 12'd4095});
        pending_pixels.push_back('{col: 12'd0, row: 12'd4095});
        pending_pixels.push_back('{col: 12'd4095, row: 12'd0});
        pending_pixels.push_back('{col: 12'd0, row: 12'd256});
        pending_pixels.push_back('{col: 12'd256, row: 12'd256});
        pending_pixels.push_back('{col: 12'd512, row: 12'd256});
        pending_pixels.push_back('{col: 12'd768, row: 12'd256});
        pending_pixels.push_back('{col: 12'd1023, row: 12'd255});
        pending_pixels.push_back('{col: 12'd1024, row: 12'd128});
        pending_pixels.push_back('{col: 12'd2100, row: 12'd300});
        pending_pixels.push_back('{col: 12'd128, row: 12'd257});
        pending_pixels.push_back('{col: 12'hAAA, row: 12'h555});
        pending_pixels.push_back('{col: 12'h555, row: 12'hAAA});
        wait_idle();

        // Register extremes: tiny and huge images, zero divisors.
        write_reg(CFG_SOURCE_DIAMETER, 16'd4095);
        write_reg(CFG_SOURCE_HEIGHT, 16'd1);
        write_reg(CFG_OUT_ROWS, 16'd1);
        write_reg(CFG_OUT_COLS, 16'd0);
        write_reg(CFG_START_PHASE, 16'd65535);
        pending_pixels.push_back('{col: 12'd0, row: 12'd1});
        pending_pixels.push_back('{col: 12'd1, row: 12'd4095});
        pending_pixels.push_back('{col: 12'd4095, row: 12'd1});
        wait_idle();
        write_reg(CFG_SOURCE_DIAMETER, 16'd0);
        write_reg(CFG_SOURCE_HEIGHT, 16'd4095);
        write_reg(CFG_OUT_ROWS, 16'd0);
        write_reg(CFG_OUT_COLS, 16'd4095);
        write_reg(CFG_START_PHASE, 16'd16384);
        pending_pixels.push_back('{col: 12'd0, row: 12'd0});
        pending_pixels.push_back('{col: 12'd2048, row: 12'd3});
        pending_pixels.push_back('{col: 12'd4095, row: 12'd4095});
        wait_idle();

        // Random phases, each with fresh settings.
        for (int ph = 0; ph < 12; ph++)
        begin
            dia = pick_reg(12'($urandom_range(1024, 16)));
            hgt = ($urandom_range(1)) ? dia : pick_reg(dia);
            rws = pick_reg(12'($urandom_range(600, 8)));
            cls = pick_reg(12'($urandom_range(2048, 8)));
            sp = (ph == 0) ? 16'd0 : (ph == 1) ? 16'hFFFF : 16'($urandom);
            write_reg(CFG_SOURCE_DIAMETER, {4'($urandom), dia});
            write_reg(CFG_SOURCE_HEIGHT, {4'($urandom), hgt});
            write_reg(CFG_OUT_ROWS, {4'($urandom), rws});
            write_reg(CFG_OUT_COLS, {4'($urandom), cls});
            write_reg(CFG_START_PHASE, sp);
            no_gaps = (ph % 4 == 3);
            for (int n = 0; n < 150; n++)
            begin
                if ($urandom_range(99) < 80)
                begin
                    px.col = (cls == 0) ? 12'd0 : 12'($urandom_range(cls - 1));
                    px.row = 12'($urandom_range(rws));
                end
                else
                begin
                    px.col = 12'($urandom);
                    px.row = 12'($urandom);
                end
                pending_pixels.push_back(px);
            end
            wait_idle();
        end

        if (mismatches == 0)
            $display("testbench passed");
        else
            $display("testbench failed");
        $finish;
    end

    initial
    begin
        #5ms;
        $display("testbench failed");
        $finish;
    end

endmodule
